// File: rtl/core/bdcq_pkg.sv
// ----------------------------------------------------------------------------
// bdcq_pkg
// Types, register codes and helpers shared by the debouncer and click queue.
// ----------------------------------------------------------------------------
package bdcq_pkg;

  // Width of the level, enable and content vectors; buttons past it are never visited.
  localparam int LEVEL_W = 8;

  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [1:0] REQ_LOCKOUT = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT   = 3'd4;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [15:0] CLICK_MAX_RST = 16'd1000;
  localparam logic [15:0] LOCKOUT_RST   = 16'd3000;
  localparam logic [7:0]  ENABLE_RST    = 8'hFF;
  localparam logic [7:0]  CONTENT_RST   = 8'hFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic [7:0]  button_levels;
  } in_t;

  typedef struct packed {
    logic        event_valid;
    logic [2:0]  event_button;
    logic [31:0] event_time_ms;
    logic [3:0]  queue_count;
    logic [7:0]  pressed_mask;
    logic        locked_out;
  } out_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] click_max_hold_ms;
    logic [15:0] lockout_ms;
    logic [7:0]  button_enable;
    logic [7:0]  content_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] last_change_ms;
    logic [31:0] press_start_ms;
  } btn_state_t;

  typedef struct packed {
    logic [2:0]  button;
    logic [31:0] stamp_ms;
  } evt_t;

  typedef struct packed {
    logic push;
    logic pop;
    evt_t evt;
  } q_ctl_t;

  typedef struct packed {
    logic       empty;
    logic [3:0] count;
  } q_stat_t;

  // The lockout holds while the end time lies ahead of now in wrapping time.
  function automatic logic lock_active(input logic [31:0] end_ms, input logic [31:0] now_ms);
    logic [31:0] d;
    d = end_ms - now_ms;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// File: rtl/core/bdcq_btn_mem.sv
// ----------------------------------------------------------------------------
// bdcq_btn_mem
// Per-button timing memory: last change time and press start time.
// ----------------------------------------------------------------------------
module bdcq_btn_mem
  import bdcq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output btn_state_t    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  btn_state_t    wr_data
);

  btn_state_t mem [DEPTH];
  btn_state_t rdata_r;
  logic [DEPTH-1:0] written_r;
  logic rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// File: rtl/core/bdcq_evt_queue.sv
// ----------------------------------------------------------------------------
// bdcq_evt_queue
// Ring queue of click events that keeps one slot free and drops the oldest.
// ----------------------------------------------------------------------------
module bdcq_evt_queue
  import bdcq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PW    = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctl_t  ctl,
  output q_stat_t stat,
  output evt_t    rd_evt
);

  localparam logic [PW-1:0] LAST   = PW'(DEPTH - 1);
  localparam logic [PW:0]   SPAN   = (PW + 1)'(DEPTH);

  evt_t mem [DEPTH];
  evt_t rdata_r;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] wr_next, rd_next;
  logic [PW:0]   fill;
  logic [31:0]   fill32;

  assign wr_next = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_next = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    if (ctl.push) begin
      wr_ptr_nxt = wr_next;
      if (wr_next == rd_ptr_r) begin
        rd_ptr_nxt = rd_next;
      end
    end else if (ctl.pop) begin
      rd_ptr_nxt = rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // The head entry is read every cycle, so it follows the registered read pointer through the read register.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.evt;
    end
    rdata_r <= mem[rd_ptr_r];
  end

  assign fill = (wr_ptr_r >= rd_ptr_r) ? {1'b0, wr_ptr_r} - {1'b0, rd_ptr_r}
                                       : {1'b0, wr_ptr_r} + SPAN - {1'b0, rd_ptr_r};
  assign fill32 = 32'(fill);

  assign stat.empty = (rd_ptr_r == wr_ptr_r);
  assign stat.count = fill32[3:0];
  assign rd_evt     = rdata_r;

endmodule

// File: rtl/core/bdcq_seq.sv
// ----------------------------------------------------------------------------
// bdcq_seq
// Request sequencer: walks the buttons through the timing memory, drives the
// event queue and holds the debounced levels, the lockout and the result.
// ----------------------------------------------------------------------------
module bdcq_seq
  import bdcq_pkg::*;
#(
  parameter int WALK = 8,
  parameter int AW   = 3,
  parameter int CW   = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  output logic          bm_rd_en,
  output logic [AW-1:0] bm_rd_addr,
  input  btn_state_t    bm_rd_data,
  output logic          bm_wr_en,
  output logic [AW-1:0] bm_wr_addr,
  output btn_state_t    bm_wr_data,
  output q_ctl_t        q_ctl,
  input  q_stat_t       q_stat,
  input  evt_t          q_rd
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [7:0]    lvl_r, lvl_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [AW-1:0] p_idx_r, p_idx_nxt;
  logic [7:0]    stable_r, stable_nxt;
  logic [31:0]   lock_end_r, lock_end_nxt;
  logic          lock_r, lock_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          accept, fin_go, ev_valid, lvl, settled, click, chg;
  logic [2:0]    pi;
  logic [31:0]   since_chg, held;

  assign accept = (state_r == S_IDLE) && in_valid;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Visit stage: the timing entry of button p_idx_r arrived from memory.
  assign pi        = 3'(p_idx_r);
  assign lvl       = lvl_r[pi];
  assign since_chg = now_r - bm_rd_data.last_change_ms;
  assign held      = now_r - bm_rd_data.press_start_ms;
  assign settled   = since_chg >= {16'd0, cfg.debounce_ms};
  assign chg       = p_vld_r && cfg.button_enable[pi] && (lvl != stable_r[pi]) && settled;
  assign click     = chg && lvl && cfg.content_mask[pi] &&
                     (held <= {16'd0, cfg.click_max_hold_ms}) && !lock_r;

  assign bm_rd_en   = (state_r == S_WALK) && (iss_r < CW'(WALK));
  assign bm_rd_addr = iss_r[AW-1:0];
  assign bm_wr_en   = chg;
  assign bm_wr_addr = p_idx_r;
  assign bm_wr_data.last_change_ms = now_r;
  assign bm_wr_data.press_start_ms = lvl ? bm_rd_data.press_start_ms : now_r;

  assign ev_valid       = (req_r == REQ_DEQUEUE) && !q_stat.empty;
  assign q_ctl.push     = click;
  assign q_ctl.pop      = fin_go && ev_valid;
  assign q_ctl.evt.button   = pi;
  assign q_ctl.evt.stamp_ms = now_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    now_nxt       = now_r;
    lvl_nxt       = lvl_r;
    iss_nxt       = iss_r;
    p_vld_nxt     = bm_rd_en;
    p_idx_nxt     = bm_rd_addr;
    stable_nxt    = stable_r;
    lock_end_nxt  = lock_end_r;
    // Settles in the cycle after the request is taken, before the first visit.
    lock_nxt      = lock_active(lock_end_r, now_r);
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (chg) begin
      stable_nxt[pi] = lvl;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data.req_type;
          now_nxt = in_data.now_ms;
          lvl_nxt = in_data.button_levels;
          iss_nxt = '0;
          if (in_data.req_type == REQ_LOCKOUT) begin
            lock_end_nxt = in_data.now_ms + {16'd0, cfg.lockout_ms};
          end
          state_nxt = (in_data.req_type == REQ_SAMPLE) ? S_WALK : S_FIN;
        end
      end
      S_WALK: begin
        if (iss_r == CW'(WALK)) begin
          state_nxt = S_FIN;
        end else begin
          iss_nxt = iss_r + 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.event_valid   = ev_valid;
          out_data_nxt.event_button  = ev_valid ? q_rd.button : 3'd0;
          out_data_nxt.event_time_ms = ev_valid ? q_rd.stamp_ms : 32'd0;
          out_data_nxt.queue_count   = ev_valid ? q_stat.count - 4'd1 : q_stat.count;
          out_data_nxt.pressed_mask  = ~stable_r;
          out_data_nxt.locked_out    = lock_active(lock_end_r, now_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      p_vld_r     <= 1'b0;
      stable_r    <= '1;
      lock_end_r  <= '0;
      lock_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      p_vld_r     <= p_vld_nxt;
      stable_r    <= stable_nxt;
      lock_end_r  <= lock_end_nxt;
      lock_r      <= lock_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    lvl_r      <= lvl_nxt;
    p_idx_r    <= p_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/button_debounce_click_queue_core.sv
// ----------------------------------------------------------------------------
// button_debounce_click_queue_core
// Debounces up to eight buttons and queues click events for later transfer.
// ----------------------------------------------------------------------------
// A sample walks the buttons: each one is read from the timing memory and then
// visited, and after the last button's visit the result is registered; a dequeue
// or lockout goes straight to the result register. The block takes no new item
// until it is back in idle after the result; a held result stalls it.
// Reset is synchronous; timing entries read as zero until first written, so no
// clearing pass is needed and items are taken right after reset.
module button_debounce_click_queue_core
  import bdcq_pkg::*;
#(
  parameter int BUTTONS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int WALK = (BUTTONS < LEVEL_W) ? BUTTONS : LEVEL_W;
  localparam int AW   = (WALK > 1) ? $clog2(WALK) : 1;
  localparam int CW   = $clog2(WALK + 1);
  localparam int PW   = $clog2(QUEUE_DEPTH);

  cfg_t          cfg_r;
  logic          bm_rd_en, bm_wr_en;
  logic [AW-1:0] bm_rd_addr, bm_wr_addr;
  btn_state_t    bm_rd_data, bm_wr_data;
  q_ctl_t        q_ctl;
  q_stat_t       q_stat;
  evt_t          q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms       <= DEBOUNCE_RST;
      cfg_r.click_max_hold_ms <= CLICK_MAX_RST;
      cfg_r.lockout_ms        <= LOCKOUT_RST;
      cfg_r.button_enable     <= ENABLE_RST;
      cfg_r.content_mask      <= CONTENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  cfg_r.debounce_ms       <= cfg_data;
        CFG_CLICK_MAX: cfg_r.click_max_hold_ms <= cfg_data;
        CFG_LOCKOUT:   cfg_r.lockout_ms        <= cfg_data;
        CFG_ENABLE:    cfg_r.button_enable     <= cfg_data[7:0];
        CFG_CONTENT:   cfg_r.content_mask      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bdcq_seq #(
    .WALK (WALK),
    .AW   (AW),
    .CW   (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .bm_rd_en   (bm_rd_en),
    .bm_rd_addr (bm_rd_addr),
    .bm_rd_data (bm_rd_data),
    .bm_wr_en   (bm_wr_en),
    .bm_wr_addr (bm_wr_addr),
    .bm_wr_data (bm_wr_data),
    .q_ctl      (q_ctl),
    .q_stat     (q_stat),
    .q_rd       (q_rd)
  );

  bdcq_btn_mem #(
    .DEPTH (WALK),
    .AW    (AW)
  ) u_btn_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data),
    .wr_en   (bm_wr_en),
    .wr_addr (bm_wr_addr),
    .wr_data (bm_wr_data)
  );

  bdcq_evt_queue #(
    .DEPTH (QUEUE_DEPTH),
    .PW    (PW)
  ) u_evt_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .stat   (q_stat),
    .rd_evt (q_rd)
  );

  // A write-back always targets the button read in the previous cycle, never the one being read.
  a_bm_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (bm_wr_en && bm_rd_en) |-> (bm_wr_addr != bm_rd_addr))
    else $error("timing memory read and write hit the same button");

  a_q_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_ctl.push && q_ctl.pop))
    else $error("event queue pushed and popped in the same cycle");

  a_q_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.pop |-> !q_stat.empty)
    else $error("event queue popped while empty");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the previous item finished");

endmodule
